// ===== rtl/core/debounced_press_counting_blinker_defines.svh =====
// Assertion macros shared by the press-counting blinker RTL.
`ifndef DEBOUNCED_PRESS_COUNTING_BLINKER_DEFINES_SVH
`define DEBOUNCED_PRESS_COUNTING_BLINKER_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define DPCB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define DPCB_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("%m: follow-up check violated");

`else

`define DPCB_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DPCB_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

// ===== rtl/core/dpcb_pkg.sv =====
// Types and constants of the debounced press-counting blinker.
`default_nettype none

package dpcb_pkg;

    // Sample history length and the pattern its reset value is cut from.
    localparam int DEBOUNCE_SAMPLES = 3;
    localparam logic [7:0] HIST_PATTERN = 8'b1010_1010;

    localparam logic [7:0] TOGGLE_CAP = 8'd254;
    localparam logic [7:0] BLINK_DELAY_RESET = 8'd8;
    localparam logic [3:0] TOGGLES_PER_PRESS_RESET = 4'd2;

    // Item kinds.
    localparam logic [1:0] KIND_FALL = 2'd0;
    localparam logic [1:0] KIND_DEBOUNCE = 2'd1;
    localparam logic [1:0] KIND_BLINK = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_BLINK_DELAY = 1'b0;
    localparam logic CFG_TOGGLES_PER_PRESS = 1'b1;

    typedef enum logic [1:0] {
        PH_SAMPLE  = 2'd0,
        PH_PRESS   = 2'd1,
        PH_RELEASE = 2'd2
    } t_phase;

    // Decoded item: kind flags one-hot or all zero, plus the pin sample.
    typedef struct packed {
        logic fall;
        logic debounce;
        logic blink;
        logic pin;
    } t_event;

    // Debouncer status after the current item.
    typedef struct packed {
        logic held;
        logic press;
    } t_dbc_status;

endpackage

`default_nettype wire

// ===== rtl/core/dpcb_in_if.sv =====
// Input channel: item kind and pin sample.
`default_nettype none

interface dpcb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       pin_level;

    modport source (output valid, output kind, output pin_level, input ready);
    modport sink (input valid, input kind, input pin_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dpcb_out_if.sv =====
// Output channel: LED level, held flag, pending toggles and press flag.
`default_nettype none

interface dpcb_out_if;
    logic       valid;
    logic       ready;
    logic       led_on;
    logic       button_held;
    logic [7:0] toggles_left;
    logic       press_accepted;

    modport source (output valid, output led_on, output button_held,
                    output toggles_left, output press_accepted, input ready);
    modport sink (input valid, input led_on, input button_held,
                  input toggles_left, input press_accepted, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/debounced_press_counting_blinker.sv =====
// Top level of the debounced press-counting blinker.
//
//   channel   dir   handshake       payload
//   i_in      in    valid/ready     kind[1:0], pin_level
//   o_out     out   valid/ready     led_on, button_held, toggles_left[7:0], press_accepted
//   i_cfg_*   in    write enable    index (0 blink delay, 1 toggles per press), data[7:0]
//
// Every beat produces one result beat after passing the input register and then the result
// register. A beat is accepted every cycle while the result side keeps up; the state update
// from input register to result register is the only step. A stalled result holds both
// registers, and input backs up behind them.
// Reset is synchronous and clears the pipeline, the debouncer and the blink state.
`default_nettype none

module debounced_press_counting_blinker #(
    parameter int DEBOUNCE_SAMPLES = dpcb_pkg::DEBOUNCE_SAMPLES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dpcb_in_if.sink    i_in,
    dpcb_out_if.source o_out,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire [7:0]  i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_pin;
    logic       r_out_valid;
    logic       r_led;
    logic       r_held;
    logic [7:0] r_toggles;
    logic       r_press;
    logic [7:0] r_delay;
    logic [3:0] r_per_press;

    logic                  step;
    dpcb_pkg::t_event      evt;
    dpcb_pkg::t_dbc_status dbc;
    logic                  n_led;
    logic [7:0]            n_toggles;

    assign step = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_comb begin
        evt = '0;
        evt.pin = r_pin;
        if (step) begin
            unique case (r_kind)
                dpcb_pkg::KIND_FALL:     evt.fall = 1'b1;
                dpcb_pkg::KIND_DEBOUNCE: evt.debounce = 1'b1;
                dpcb_pkg::KIND_BLINK:    evt.blink = 1'b1;
                default: ;
            endcase
        end
    end

    dpcb_debounce #(
        .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
    ) u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (evt),
        .o_status (dbc)
    );

    dpcb_blink u_blink (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blink     (evt.blink),
        .i_press     (dbc.press),
        .i_delay     (r_delay),
        .i_per_press (r_per_press),
        .o_led       (n_led),
        .o_pending   (n_toggles)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_pin  <= i_in.pin_level;
        end
        if (step) begin
            r_led     <= n_led;
            r_held    <= dbc.held;
            r_toggles <= n_toggles;
            r_press   <= dbc.press;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= dpcb_pkg::BLINK_DELAY_RESET;
            r_per_press <= dpcb_pkg::TOGGLES_PER_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpcb_pkg::CFG_BLINK_DELAY:       r_delay <= i_cfg_data;
                dpcb_pkg::CFG_TOGGLES_PER_PRESS: r_per_press <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.led_on         = r_led;
    assign o_out.button_held    = r_held;
    assign o_out.toggles_left   = r_toggles;
    assign o_out.press_accepted = r_press;

endmodule

`default_nettype wire

// ===== rtl/core/dpcb_debounce.sv =====
// Shift-register debouncer with sampling, press and release phases.
`default_nettype none
`include "debounced_press_counting_blinker_defines.svh"

module dpcb_debounce #(
    parameter int DEBOUNCE_SAMPLES = dpcb_pkg::DEBOUNCE_SAMPLES
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire dpcb_pkg::t_event i_event,
    output dpcb_pkg::t_dbc_status o_status
);

    localparam logic [DEBOUNCE_SAMPLES-1:0] HistReset =
        DEBOUNCE_SAMPLES'(dpcb_pkg::HIST_PATTERN);

    dpcb_pkg::t_phase r_phase, n_phase;
    logic [DEBOUNCE_SAMPLES-1:0] r_hist, n_hist, shifted;
    logic r_held, n_held;
    logic r_active, n_active;
    logic tick;
    logic press;

    assign tick = i_event.debounce && r_active;
    assign shifted = {r_hist[DEBOUNCE_SAMPLES-2:0], i_event.pin};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (tick) begin
            unique case (r_phase)
                dpcb_pkg::PH_SAMPLE: begin
                    if (!r_held && (shifted == '0)) begin
                        n_phase = dpcb_pkg::PH_PRESS;
                    end else if (shifted == '1) begin
                        n_phase = dpcb_pkg::PH_RELEASE;
                    end else begin
                        n_phase = dpcb_pkg::PH_SAMPLE;
                    end
                end
                default: n_phase = dpcb_pkg::PH_SAMPLE;
            endcase
        end
    end

    // Phase actions.
    always_comb begin
        n_hist   = r_hist;
        n_held   = r_held;
        n_active = r_active;
        press    = 1'b0;
        if (i_event.fall) begin
            n_active = 1'b1;
        end else if (tick) begin
            unique case (r_phase)
                dpcb_pkg::PH_SAMPLE: n_hist = shifted;
                dpcb_pkg::PH_PRESS: begin
                    n_held = 1'b1;
                    press  = 1'b1;
                end
                dpcb_pkg::PH_RELEASE: begin
                    n_held   = 1'b0;
                    n_active = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dpcb_pkg::PH_SAMPLE;
            r_hist   <= HistReset;
            r_held   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hist   <= n_hist;
            r_held   <= n_held;
            r_active <= n_active;
        end
    end

    assign o_status.held  = n_held;
    assign o_status.press = press;

    // A press is only registered while none is held, and it is held after.
    `DPCB_ASSERT_ALWAYS(a_press_not_held, i_clk, i_rst_n, !press || !r_held)
    `DPCB_ASSERT_NEXT(a_press_sets_held, i_clk, i_rst_n, press, r_held)
    `DPCB_ASSERT_NEXT(a_release_disables, i_clk, i_rst_n,
        tick && (r_phase == dpcb_pkg::PH_RELEASE), !r_active && !r_held)

endmodule

`default_nettype wire

// ===== rtl/core/dpcb_blink.sv =====
// Pending toggle count, wait counter and LED level.
`default_nettype none
`include "debounced_press_counting_blinker_defines.svh"

module dpcb_blink (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_blink,
    input  wire                   i_press,
    input  wire  [7:0]            i_delay,
    input  wire  [3:0]            i_per_press,
    output logic                  o_led,
    output logic [7:0]            o_pending
);

    logic [7:0] r_pending, n_pending;
    logic [7:0] r_wait, n_wait;
    logic       r_led, n_led;
    logic [8:0] sum;
    logic [7:0] wait_inc;

    assign sum = {1'b0, r_pending} + {5'd0, i_per_press};
    assign wait_inc = r_wait + 8'd1;

    always_comb begin
        n_pending = r_pending;
        n_wait    = r_wait;
        n_led     = r_led;
        if (i_press) begin
            n_pending = (sum > {1'b0, dpcb_pkg::TOGGLE_CAP}) ? dpcb_pkg::TOGGLE_CAP
                                                             : sum[7:0];
            n_wait    = '0;
        end else if (i_blink) begin
            n_wait = wait_inc;
            // Toggling starts once the wait counter has caught up with the delay.
            if ((wait_inc >= i_delay) && (r_pending != '0)) begin
                n_led     = ~r_led;
                n_pending = r_pending - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_wait    <= '0;
            r_led     <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_wait    <= n_wait;
            r_led     <= n_led;
        end
    end

    assign o_led     = n_led;
    assign o_pending = n_pending;

    `DPCB_ASSERT_ALWAYS(a_pending_capped, i_clk, i_rst_n, r_pending <= dpcb_pkg::TOGGLE_CAP)
    `DPCB_ASSERT_NEXT(a_flip_uses_toggle, i_clk, i_rst_n, n_led != r_led,
        r_pending == ($past(r_pending) - 8'd1))

endmodule

`default_nettype wire
